/* hw/rtl/object_header_parser_top_assert.svh */
// ----------------------------------------------------------------------------
// object header parser assertion macros
// shared property forms for the parser checks
// ----------------------------------------------------------------------------
`ifndef OBJECT_HEADER_PARSER_TOP_ASSERT_SVH
`define OBJECT_HEADER_PARSER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define OHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define OHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/ohp_pkg.sv */
// ----------------------------------------------------------------------------
// ohp_pkg
// types and constants for the object header parser
// ----------------------------------------------------------------------------
package ohp_pkg;

    // width of the saturating length counter
    localparam int LENGTH_BITS = 16;

    localparam logic [31:0] LENGTH_FULL = (32'd1 << LENGTH_BITS) - 32'd1;
    localparam logic [15:0] LENGTH_LIMIT =
        (LENGTH_BITS >= 16) ? 16'hFFFF : LENGTH_FULL[15:0];

    // name register geometry
    localparam int NAME_MAX = 6;

    // recognized names, packed as they are shifted in
    localparam logic [47:0] NAME_BLOB   = 48'h0000_626C_6F62;
    localparam logic [47:0] NAME_TREE   = 48'h0000_7472_6565;
    localparam logic [47:0] NAME_COMMIT = 48'h636F_6D6D_6974;
    localparam logic [47:0] NAME_TAG    = 48'h0000_0074_6167;

    // object type codes
    localparam logic [1:0] TYPE_BLOB   = 2'd0;
    localparam logic [1:0] TYPE_TREE   = 2'd1;
    localparam logic [1:0] TYPE_COMMIT = 2'd2;
    localparam logic [1:0] TYPE_TAG    = 2'd3;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // characters
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // largest accumulator value that takes a digit up to 5 without wrap
    localparam logic [63:0] SIZE_GUARD = 64'h1999_9999_9999_9999;
    localparam logic [63:0] SIZE_GUARD_DIGIT = 64'd5;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_NAME = 2'd1,
        PH_SIZE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [1:0]  object_type;
        logic [63:0] obj_size;
        logic        size_overflow;
        logic [15:0] header_length;
    } t_out_item;

    // result of one parse step
    typedef struct packed {
        logic      fire;
        t_out_item item;
    } t_step_res;

endpackage

/* hw/rtl/ohp_step.sv */
// ----------------------------------------------------------------------------
// ohp_step
// parser state and the per-byte update, one byte per enabled cycle
// ----------------------------------------------------------------------------
module ohp_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  ohp_pkg::t_in_item i_item,
    output ohp_pkg::t_step_res o_res
);
    import ohp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [47:0] r_chars, n_chars;
    logic [2:0]  r_len, n_len;
    logic [63:0] r_acc, n_acc;
    logic        r_ov, n_ov;
    logic [15:0] r_cnt, n_cnt;
    logic [1:0]  r_type, n_type;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_chars <= '0;
            r_len   <= '0;
            r_acc   <= '0;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_type  <= TYPE_BLOB;
        end else begin
            r_phase <= n_phase;
            r_chars <= n_chars;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
            r_type  <= n_type;
        end
    end

    // next state and result
    always_comb begin
        logic        active;
        logic        known;
        logic [1:0]  mtype;
        logic [7:0]  b;
        logic [63:0] digit;
        t_phase      cur_phase;

        n_phase = r_phase;
        n_chars = r_chars;
        n_len   = r_len;
        n_acc   = r_acc;
        n_ov    = r_ov;
        n_cnt   = r_cnt;
        n_type  = r_type;
        o_res   = '0;
        o_res.item.status = ST_ERR;
        b       = i_item.data_byte;
        digit   = 64'(b - CHAR_ZERO);
        known   = 1'b0;
        mtype   = TYPE_BLOB;
        cur_phase = r_phase;

        // first byte restarts the parse
        if (i_item.first_byte) begin
            n_chars   = '0;
            n_len     = '0;
            n_acc     = '0;
            n_ov      = 1'b0;
            n_cnt     = '0;
            cur_phase = PH_NAME;
            n_phase   = PH_NAME;
        end
        active = i_en && (cur_phase == PH_NAME || cur_phase == PH_SIZE);

        // name lookup on the current name register
        if (n_len == 3'd4 && n_chars == NAME_BLOB) begin
            known = 1'b1;
            mtype = TYPE_BLOB;
        end else if (n_len == 3'd4 && n_chars == NAME_TREE) begin
            known = 1'b1;
            mtype = TYPE_TREE;
        end else if (n_len == 3'd6 && n_chars == NAME_COMMIT) begin
            known = 1'b1;
            mtype = TYPE_COMMIT;
        end else if (n_len == 3'd3 && n_chars == NAME_TAG) begin
            known = 1'b1;
            mtype = TYPE_TAG;
        end

        if (!i_en) begin
            // hold everything when no byte is processed
            n_phase = r_phase;
            n_chars = r_chars;
            n_len   = r_len;
            n_acc   = r_acc;
            n_ov    = r_ov;
            n_cnt   = r_cnt;
        end else if (active) begin
            if (n_cnt < LENGTH_LIMIT) begin
                n_cnt = n_cnt + 16'd1;
            end
            unique case (cur_phase)
                PH_NAME: begin
                    if (b == CHAR_SPACE) begin
                        if (!known || i_item.last_byte) begin
                            o_res.fire = 1'b1;
                            n_phase    = PH_IDLE;
                        end else begin
                            n_type  = mtype;
                            n_phase = PH_SIZE;
                        end
                    end else if (n_len >= 3'(NAME_MAX)) begin
                        o_res.fire = 1'b1;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_chars = {n_chars[39:0], b};
                        n_len   = n_len + 3'd1;
                        if (i_item.last_byte) begin
                            o_res.fire = 1'b1;
                            n_phase    = PH_IDLE;
                        end
                    end
                end
                PH_SIZE: begin
                    if (b == CHAR_NUL) begin
                        // header complete
                        o_res.fire               = 1'b1;
                        o_res.item.status        = ST_OK;
                        o_res.item.object_type   = r_type;
                        o_res.item.obj_size      = n_acc;
                        o_res.item.size_overflow = n_ov;
                        o_res.item.header_length = n_cnt;
                        n_phase                  = PH_IDLE;
                    end else if (b < CHAR_ZERO || b > CHAR_NINE) begin
                        o_res.fire = 1'b1;
                        n_phase    = PH_IDLE;
                    end else begin
                        // acc * 10 + digit, wrapping
                        if (n_acc > SIZE_GUARD ||
                            (n_acc == SIZE_GUARD && digit > SIZE_GUARD_DIGIT)) begin
                            n_ov = 1'b1;
                        end
                        n_acc = (n_acc << 3) + (n_acc << 1) + digit;
                        if (i_item.last_byte) begin
                            o_res.fire = 1'b1;
                            n_phase    = PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else begin
            // idle byte without a start: no change
            n_phase = r_phase;
            n_chars = r_chars;
            n_len   = r_len;
            n_acc   = r_acc;
            n_ov    = r_ov;
            n_cnt   = r_cnt;
        end
    end

endmodule

/* hw/rtl/object_header_parser_top.sv */
// A byte's result is registered: it passes the input register and then the result register
// before it shows at the output. One byte per cycle is taken while the input register is
// empty or the result register is free or being drained; the parse step is combinational
// between the two registers. Bytes that cause no result leave nothing at the output.
// Reset (synchronous, active low) empties both registers and returns the
// parser to idle, waiting for a first byte.
// ----------------------------------------------------------------------------
// object_header_parser_top
// streaming "TYPE SIZE\0" object header parser with valid/ready channels
// ----------------------------------------------------------------------------
module object_header_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ohp_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ohp_pkg::t_out_item o_out
);
    import ohp_pkg::*;

    `include "object_header_parser_top_assert.svh"

    logic      r_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;
    logic      step_en;
    t_step_res step_res;
    logic      out_err;
    logic      out_ok;
    logic      err_clean;

    // pipeline moves when the result register is free or being drained
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || advance;
    assign step_en    = r_s1_valid && advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1 <= i_in;
        end
    end

    // parse step
    ohp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step_en),
        .i_item  (r_s1),
        .o_res   (step_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_en && step_res.fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en && step_res.fire) begin
            r_out <= step_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // check terms
    assign out_err   = o_out_valid && (o_out.status == ST_ERR);
    assign out_ok    = o_out_valid && (o_out.status == ST_OK);
    assign err_clean = (o_out.object_type == TYPE_BLOB) && (o_out.obj_size == 64'd0)
                       && !o_out.size_overflow && (o_out.header_length == 16'd0);

    // checks
    `OHP_ASSERT_IMP(a_err_fields_zero, i_clk, i_rst_n, out_err, err_clean)
    `OHP_ASSERT_IMP(a_ok_min_length, i_clk, i_rst_n, out_ok, o_out.header_length >= 16'd5)
    `OHP_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    `OHP_ASSERT_NXT(a_fire_loads_result, i_clk, i_rst_n, step_en && step_res.fire, o_out_valid)

endmodule
